// ===== rtl/core/rwq_pkg.sv =====
// rwq_pkg: shared types, codes and defaults for the latch wait queue
// no dependencies; compiled first
package rwq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  typedef logic [1:0] op_t;
  typedef logic [1:0] purpose_t;
  typedef logic [7:0] id_t;

  localparam op_t OP_ENQUEUE   = 2'd0;
  localparam op_t OP_WAKE_NEXT = 2'd1;
  localparam op_t OP_WAKE_ALL  = 2'd2;

  localparam purpose_t P_OPT   = 2'd0;
  localparam purpose_t P_READ  = 2'd1;
  localparam purpose_t P_WRITE = 2'd2;
  localparam purpose_t P_REBAL = 2'd3;

  // stored waiter: purpose in the upper bits, id below
  typedef struct packed {
    purpose_t purpose;
    id_t      id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_STATUS,
    S_ROT_RD,
    S_ROT_CHK,
    S_REL_RD,
    S_REL_CHK,
    S_FLUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic init_wake;
    logic issue_rd;
    logic emit_status;
    logic rot_move;
    logic grp_set;
    logic rel_take;
    logic emit_flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic out_free;
    logic head_opt;
    logic rot_last;
    logic take_ok;
    logic rel_end;
    logic hold_v;
  } sts_t;

endpackage

// ===== rtl/core/rwq_if.sv =====
// rwq_in_if / rwq_out_if: valid/ready channels of the wait queue
// depends on rwq_pkg
interface rwq_in_if;
  import rwq_pkg::*;
  logic     valid;
  logic     ready;
  op_t      op;
  purpose_t purpose;
  id_t      waiter_id;

  modport source (output valid, op, purpose, waiter_id, input ready);
  modport sink (input valid, op, purpose, waiter_id, output ready);
endinterface

interface rwq_out_if;
  import rwq_pkg::*;
  logic     valid;
  logic     ready;
  id_t      woken_id;
  purpose_t woken_purpose;
  logic     none_woken;
  logic     overflow;
  logic     last;

  modport source (output valid, woken_id, woken_purpose, none_woken, overflow, last,
                  input ready);
  modport sink (input valid, woken_id, woken_purpose, none_woken, overflow, last,
                output ready);
endinterface

// ===== rtl/core/rwq_ram.sv =====
// rwq_ram: generic single write, single read ram with registered read data
// no dependencies
module rwq_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rwq_ctrl.sv =====
// rwq_ctrl: sequencer of the wait queue (decode, rotate, release, flush)
// depends on rwq_pkg; drives the datapath through cmd_t, reads sts_t
module rwq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rwq_pkg::sts_t sts,
  output rwq_pkg::cmd_t cmd
);
  import rwq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.op)
          OP_WAKE_NEXT: state_nxt = sts.empty ? S_STATUS : S_ROT_RD;
          OP_WAKE_ALL:  state_nxt = sts.empty ? S_STATUS : S_REL_RD;
          default:      state_nxt = S_STATUS;
        endcase
      end
      S_STATUS: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_ROT_RD: state_nxt = S_ROT_CHK;
      S_ROT_CHK: begin
        if (sts.head_opt) begin
          state_nxt = sts.rot_last ? S_REL_RD : S_ROT_RD;
        end else begin
          state_nxt = S_REL_CHK;
        end
      end
      S_REL_RD: state_nxt = S_REL_CHK;
      S_REL_CHK: begin
        if (!sts.take_ok) begin
          state_nxt = S_FLUSH;
        end else if (!sts.hold_v || sts.out_free) begin
          state_nxt = sts.rel_end ? S_FLUSH : S_REL_RD;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_DECODE:  cmd.init_wake = 1'b1;
      S_STATUS:  cmd.emit_status = sts.out_free;
      S_ROT_RD:  cmd.issue_rd = 1'b1;
      S_ROT_CHK: begin
        cmd.rot_move = sts.head_opt;
        cmd.grp_set  = !sts.head_opt;
      end
      S_REL_RD:  cmd.issue_rd = 1'b1;
      S_REL_CHK: cmd.rel_take = sts.take_ok && (!sts.hold_v || sts.out_free);
      S_FLUSH:   cmd.emit_flush = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/rwq_dp.sv =====
// rwq_dp: queue pointers, waiter store, held result and output register
// depends on rwq_pkg and rwq_ram; steered by rwq_ctrl through cmd_t
module rwq_dp #(
  parameter int QUEUE_DEPTH = rwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rwq_pkg::cmd_t     cmd,
  output rwq_pkg::sts_t     sts,
  input  rwq_pkg::op_t      in_op,
  input  rwq_pkg::purpose_t in_purpose,
  input  rwq_pkg::id_t      in_waiter_id,
  output logic              out_valid,
  input  logic              out_ready,
  output rwq_pkg::id_t      out_woken_id,
  output rwq_pkg::purpose_t out_woken_purpose,
  output logic              out_none_woken,
  output logic              out_overflow,
  output logic              out_last
);
  import rwq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(QUEUE_DEPTH);

  op_t      op_r;
  purpose_t purpose_r;
  id_t      id_r;

  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rot_r, rot_nxt;
  logic          all_r, all_nxt;
  purpose_t      grp_r, grp_nxt;
  entry_t        hold_r, hold_nxt;
  logic          hold_v_r, hold_v_nxt;

  logic          out_valid_r, out_valid_nxt;
  id_t           out_id_r, out_id_nxt;
  purpose_t      out_purp_r, out_purp_nxt;
  logic          out_none_r, out_none_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  logic          out_last_r, out_last_nxt;

  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [CW:0]        tail_sum;
  logic [IW-1:0]      tail_idx;
  logic [IW-1:0]      head_inc;
  logic               full;
  logic               enq_write;
  logic               out_free;
  logic               out_load;

  assign rd_entry = entry_t'(ram_rdata);
  assign full     = (count_r == DEPTH_C);
  assign out_free = !out_valid_r || out_ready;

  // circular index arithmetic
  assign tail_sum = (CW + 1)'(head_r) + (CW + 1)'(count_r);
  assign tail_idx = (tail_sum >= DEPTH_W) ? IW'(tail_sum - DEPTH_W) : IW'(tail_sum);
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;

  // appends and rotations both write at the tail
  assign enq_write = cmd.emit_status && (op_r == OP_ENQUEUE) && !full;
  assign ram_we    = enq_write || cmd.rot_move;
  assign ram_wdata = cmd.rot_move ? ram_rdata : {purpose_r, id_r};

  rwq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_idx),
    .wdata (ram_wdata),
    .re    (cmd.issue_rd),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.op       = op_r;
    sts.full     = full;
    sts.empty    = (count_r == '0);
    sts.out_free = out_free;
    sts.head_opt = (rd_entry.purpose == P_OPT);
    sts.rot_last = ((rot_r + 1'b1) == count_r);
    sts.take_ok  = !hold_v_r || all_r || (rd_entry.purpose == grp_r);
    sts.rel_end  = (count_r == CW'(1)) || (!all_r && (grp_r == P_WRITE));
    sts.hold_v   = hold_v_r;
  end

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    rot_nxt    = rot_r;
    all_nxt    = all_r;
    grp_nxt    = grp_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;

    if (cmd.init_wake) begin
      rot_nxt    = '0;
      all_nxt    = (op_r == OP_WAKE_ALL);
      hold_v_nxt = 1'b0;
    end
    if (enq_write) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.rot_move) begin
      head_nxt = head_inc;
      rot_nxt  = rot_r + 1'b1;
      if (sts.rot_last) all_nxt = 1'b1;
    end
    if (cmd.grp_set) begin
      grp_nxt = rd_entry.purpose;
    end
    if (cmd.rel_take) begin
      head_nxt   = head_inc;
      count_nxt  = count_r - 1'b1;
      hold_nxt   = rd_entry;
      hold_v_nxt = 1'b1;
    end
    if (cmd.emit_flush) begin
      hold_v_nxt = 1'b0;
    end
  end

  // a held waiter goes out once the next one is taken (same group, or any waiter in wake-all) or at flush
  assign out_load = cmd.emit_status || cmd.emit_flush || (cmd.rel_take && hold_v_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_id_nxt    = out_id_r;
    out_purp_nxt  = out_purp_r;
    out_none_nxt  = out_none_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (cmd.emit_status) begin
        out_id_nxt   = '0;
        out_purp_nxt = P_OPT;
        out_none_nxt = 1'b1;
        out_ovf_nxt  = (op_r == OP_ENQUEUE) && full;
        out_last_nxt = 1'b1;
      end else begin
        out_id_nxt   = hold_r.id;
        out_purp_nxt = hold_r.purpose;
        out_none_nxt = 1'b0;
        out_ovf_nxt  = 1'b0;
        out_last_nxt = cmd.emit_flush;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r      <= in_op;
      purpose_r <= in_purpose;
      id_r      <= in_waiter_id;
    end
    rot_r      <= rot_nxt;
    all_r      <= all_nxt;
    grp_r      <= grp_nxt;
    hold_r     <= hold_nxt;
    out_id_r   <= out_id_nxt;
    out_purp_r <= out_purp_nxt;
    out_none_r <= out_none_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_woken_id      = out_id_r;
  assign out_woken_purpose = out_purp_r;
  assign out_none_woken    = out_none_r;
  assign out_overflow      = out_ovf_r;
  assign out_last          = out_last_r;

endmodule

// ===== rtl/core/rw_latch_wait_queue_waker.sv =====
// rw_latch_wait_queue_waker: wait queue of a reader/writer/rebalancer latch
// depends on rwq_pkg, rwq_if, rwq_ctrl, rwq_dp (which holds rwq_ram)
//
// usage
//   in_ch carries one command transaction: enqueue a waiter (purpose, id),
//   wake the next group, or wake every waiter. out_ch carries the results:
//   one transaction per released waiter, or a single status transaction
//   (none_woken, with overflow when an enqueue hits a full queue); the
//   final transaction of each command has last set.
// sequencing
//   one command at a time; in_ch.ready is high only while the block is idle.
//   enqueue, empty wake, unused op: a single status result after accept.
//   wake-all: one result per queued waiter, released in queue order.
//   wake-next: optimistic waiters at the head are rotated to the tail, then
//   the run of same-purpose waiters at the head is released (a writer alone);
//   when all are optimistic, all are released; paced by the store's read port.
// reset
//   rst_n (synchronous, active low) empties the queue and the output
//   register; the store itself is not cleared, only occupied slots are read.
// back-pressure
//   a stalled out_ch holds the current result; the sequencer waits with the
//   next one and takes no new command until the last result is loaded.
module rw_latch_wait_queue_waker #(
  parameter int QUEUE_DEPTH = rwq_pkg::QUEUE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rwq_in_if.sink    in_ch,
  rwq_out_if.source out_ch
);
  import rwq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: decode, rotate optimistic readers, release, flush last
  rwq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // pointers, waiter store and output register
  rwq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_ch.op),
    .in_purpose        (in_ch.purpose),
    .in_waiter_id      (in_ch.waiter_id),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_woken_id      (out_ch.woken_id),
    .out_woken_purpose (out_ch.woken_purpose),
    .out_none_woken    (out_ch.none_woken),
    .out_overflow      (out_ch.overflow),
    .out_last          (out_ch.last)
  );

endmodule

// ===== rtl/core/rwq_checker.sv =====
// rwq_checker: port-level checks of the wait queue, bound to the top level
// depends on rwq_pkg
module rwq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input rwq_pkg::id_t      out_woken_id,
  input rwq_pkg::purpose_t out_woken_purpose,
  input logic              out_none_woken,
  input logic              out_overflow,
  input logic              out_last
);
  import rwq_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_woken_id, out_woken_purpose, out_none_woken, out_overflow, out_last}))
    else $error("result changed while stalled");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  // status result is alone and carries no waiter
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_woken |-> out_last && (out_woken_id == '0) &&
      (out_woken_purpose == P_OPT))
    else $error("malformed status result");

  // overflow only on a status result
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_none_woken)
    else $error("overflow on a released waiter");

endmodule

bind rw_latch_wait_queue_waker rwq_checker u_rwq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_woken_id      (out_ch.woken_id),
  .out_woken_purpose (out_ch.woken_purpose),
  .out_none_woken    (out_ch.none_woken),
  .out_overflow      (out_ch.overflow),
  .out_last          (out_ch.last)
);
